>>> rtl/core/pts_pkg.sv
package pts_pkg;

  // Datapath sizing
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
  localparam int POT_BITS        = 16;
  localparam int STEP_REG_BITS   = 31;
  localparam int AMP_BITS        = 15;
  localparam int AMP_FRAC        = 15;
  localparam int STEP_BITS       = STEP_REG_BITS + 1;
  localparam int SPAN_PROD_BITS  = POT_BITS + STEP_REG_BITS;
  localparam int SUM_BITS        = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;
  localparam int PROD_BITS       = SAMPLE_BITS + AMP_BITS + 1;

  // Configuration port
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = STEP_REG_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_STEP  = 2'd0,
    REG_STEP_SPAN = 2'd1,
    REG_AMPLITUDE = 2'd2
  } cfg_reg_t;

  localparam logic [STEP_REG_BITS-1:0] MIN_STEP_RST  = 31'd4473924;
  localparam logic [STEP_REG_BITS-1:0] STEP_SPAN_RST = 31'd174483047;
  localparam logic [AMP_BITS-1:0]      AMPLITUDE_RST = 15'd8192;

  // Sine table generation, evaluated at elaboration only
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] PEAK        = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [63:0] QUARTER     = 64'd1 << (TABLE_ADDR_BITS - 2);

  typedef logic [63:0] taylor_div_t [7];
  // n*(n-1) for n = 15, 13, ..., 3
  localparam taylor_div_t TAYLOR_DIV = '{64'd210, 64'd156, 64'd110, 64'd72,
                                         64'd42, 64'd20, 64'd6};

  typedef logic signed [SAMPLE_BITS-1:0] sine_rom_t [TABLE_DEPTH];

  // sin(pi/2 * m / QUARTER) in Q30, Horner form of the Taylor series
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (HALF_PI_Q30 * m) >> (TABLE_ADDR_BITS - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 7; k++) begin
      t = Q30_ONE - (x2 * t) / TAYLOR_DIV[k];
    end
    return (x * t) >> 30;
  endfunction

  // Full-wave entry from quarter-wave symmetry
  function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(
      input logic [TABLE_ADDR_BITS-1:0] idx);
    logic [1:0]  quad;
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] mag;
    quad = idx[TABLE_ADDR_BITS-1 -: 2];
    m    = 64'(idx[TABLE_ADDR_BITS-3:0]);
    if (quad[0]) begin
      m = QUARTER - m;
    end
    s   = quarter_sine_q30(m);
    mag = (s * PEAK + (Q30_ONE >> 1)) >> 30;
    if (mag > PEAK) begin
      mag = PEAK;
    end
    if (quad[1]) begin
      mag = 64'd0 - mag;
    end
    return SAMPLE_BITS'(mag);
  endfunction

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(TABLE_ADDR_BITS'(k));
    end
    return rom;
  endfunction

endpackage

>>> rtl/core/pts_in_if.sv
interface pts_in_if import pts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POT_BITS-1:0] pot_level;

  modport source (output valid, output pot_level, input ready);
  modport sink   (input valid, input pot_level, output ready);
endinterface

>>> rtl/core/pts_out_if.sv
interface pts_out_if import pts_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

>>> rtl/core/pot_tuned_sine_oscillator.sv
// Pot-tuned DDS sine oscillator. Each accepted item is one sample tick carrying a
// pot reading; each tick yields one stereo result, left equal to right, taken from the
// sine table at the phase before that tick's step (min_step + (pot * step_span) >> 16)
// is added. One item per clock is sustained while the result side is not stalled. The
// pot-by-span product is registered into span_r when the item is accepted, the phase add
// and the registered sine ROM read then fill rom_q_r, and the amplitude multiplier feeds
// the output register sample_r.
// Each stage advances when the one after it is empty or draining, so stalls on the
// result side back up only as far as they must. The 1024-entry sine ROM is built at
// elaboration; the phase resets to zero. Write configuration only while idle.
module pot_tuned_sine_oscillator import pts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  pts_in_if.sink                   in_ch,
  pts_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  // Configuration registers
  logic [STEP_REG_BITS-1:0] min_step_r;
  logic [STEP_REG_BITS-1:0] step_span_r;
  logic [AMP_BITS-1:0]      amplitude_r;

  // Pipeline state
  logic                            s1_v_r;
  logic [STEP_REG_BITS-1:0]        span_r;
  logic [STEP_REG_BITS-1:0]        span_nxt;
  logic                            s2_v_r;
  logic signed [SAMPLE_BITS-1:0]   rom_q_r;
  logic [PHASE_BITS-1:0]           phase_r;
  logic [PHASE_BITS-1:0]           phase_nxt;
  logic                            out_v_r;
  logic signed [SAMPLE_BITS-1:0]   sample_r;
  logic signed [SAMPLE_BITS-1:0]   sample_nxt;

  logic [SPAN_PROD_BITS-1:0]       span_prod;
  logic [STEP_BITS-1:0]            step;
  logic signed [PROD_BITS-1:0]     amp_prod;
  logic                            out_free;
  logic                            s2_free;
  logic                            s1_free;
  logic                            move_in;
  logic                            move_12;
  logic                            move_23;

  // Write configuration; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r  <= MIN_STEP_RST;
      step_span_r <= STEP_SPAN_RST;
      amplitude_r <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_STEP:  min_step_r  <= cfg_data[STEP_REG_BITS-1:0];
        REG_STEP_SPAN: step_span_r <= cfg_data[STEP_REG_BITS-1:0];
        REG_AMPLITUDE: amplitude_r <= cfg_data[AMP_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // Stage flow control
  always_comb begin
    out_free = !out_v_r || out_ch.ready;
    s2_free  = !s2_v_r || out_free;
    s1_free  = !s1_v_r || s2_free;
    move_in  = in_ch.valid && s1_free;
    move_12  = s1_v_r && s2_free;
    move_23  = s2_v_r && out_free;
  end

  assign in_ch.ready = s1_free;

  // Datapath
  always_comb begin
    span_prod  = in_ch.pot_level * step_span_r;
    span_nxt   = span_prod[SPAN_PROD_BITS-1 -: STEP_REG_BITS];
    step       = STEP_BITS'(min_step_r) + STEP_BITS'(span_r);
    phase_nxt  = PHASE_BITS'(SUM_BITS'(phase_r) + SUM_BITS'(step));
    amp_prod   = rom_q_r * $signed({1'b0, amplitude_r});
    sample_nxt = amp_prod[AMP_FRAC + SAMPLE_BITS - 1 : AMP_FRAC];
  end

  // Valid bits and phase accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      // Advance the phase once per item leaving stage one
      if (move_12) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (move_in) begin
      span_r <= span_nxt;
    end
    // Read the table at the phase before this item's step
    if (move_12) begin
      rom_q_r <= SINE_ROM[phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS]];
    end
    if (move_23) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.left_sample  = sample_r;
  assign out_ch.right_sample = sample_r;

endmodule

>>> rtl/core/pts_checker.sv
module pts_checker import pts_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] left_sample,
  input logic signed [SAMPLE_BITS-1:0] right_sample
);

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_sample))
    else $error("result changed while stalled");

  // Both channels carry the same sample
  a_stereo_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> left_sample == right_sample)
    else $error("left and right samples differ");

  // Table peak and gain below one keep the sample off the most negative code
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> left_sample != MOST_NEG)
    else $error("sample reached the most negative code");

  // A free output slot means the whole pipeline can move
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the output was free");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pot_tuned_sine_oscillator pts_checker u_pts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .left_sample  (out_ch.left_sample),
  .right_sample (out_ch.right_sample)
);
